// ===== sv/i2c_master_bit_sequencer_macros.svh =====
// Assertion macros for the I2C master bit sequencer
`ifndef I2C_MASTER_BIT_SEQUENCER_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every clock edge outside reset
`define I2CMBS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("i2cmbs: same-cycle check failed");
// Next-cycle implication
`define I2CMBS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("i2cmbs: next-cycle check failed");
`else
`define I2CMBS_ASSERT_NOW(label, ante, cons)
`define I2CMBS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/i2cmbs_pkg.sv =====
package i2cmbs_pkg;

   // bits shifted per byte and the width of the bit counter
   localparam int unsigned BITS_PER_BYTE = 8;
   localparam int unsigned BITS_W        = $clog2(BITS_PER_BYTE + 1);

   localparam int unsigned DELAY_W       = 16;
   localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd100;

   // command codes
   typedef enum logic [2:0] {
      ACT_NONE  = 3'd0,
      ACT_START = 3'd1,
      ACT_STOP  = 3'd2,
      ACT_WRITE = 3'd3,
      ACT_READ  = 3'd4,
      ACT_BUSY  = 3'd5
   } action_type;

   // completion status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_BUSY = 2'd1;
   localparam logic [1:0] STATUS_NACK = 2'd2;

   // sequencer steps, one-hot
   typedef enum logic [20:0] {
      ST_IDLE = 21'h000001,
      ST_S0   = 21'h000002,
      ST_S1   = 21'h000004,
      ST_S2   = 21'h000008,
      ST_P0   = 21'h000010,
      ST_P1   = 21'h000020,
      ST_P2   = 21'h000040,
      ST_B0   = 21'h000080,
      ST_W0   = 21'h000100,
      ST_WA   = 21'h000200,
      ST_WB   = 21'h000400,
      ST_WC   = 21'h000800,
      ST_WD   = 21'h001000,
      ST_WE   = 21'h002000,
      ST_WF   = 21'h004000,
      ST_R0   = 21'h008000,
      ST_RA   = 21'h010000,
      ST_RB   = 21'h020000,
      ST_RC   = 21'h040000,
      ST_RD   = 21'h080000,
      ST_RE   = 21'h100000
   } seq_state_type;

   // one result item
   typedef struct packed {
      logic       scl_pull_low;
      logic       sda_pull_low;
      logic       ready_res;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] read_data;
   } rsp_item_type;

endpackage

// ===== sv/i2c_master_bit_sequencer.sv =====
// I2C master bit sequencer: one input item per clock tick of the line sequence.
// The result item of an accepted item is registered in the output buffer before it reaches rsp_.
// Throughput: one item per cycle while req_stall is low; a two-entry output buffer (result register
// plus skid register) lets input continue while one result waits.
// Reset (synchronous, active high): idle, both lines released, delay unit 100 ticks.
`include "i2c_master_bit_sequencer_macros.svh"

module i2c_master_bit_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [2:0]                          req_action,
   input  logic [7:0]                          req_write_data,
   input  logic                                req_send_nack,
   input  logic                                req_scl_level,
   input  logic                                req_sda_level,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_scl_pull_low,
   output logic                                rsp_sda_pull_low,
   output logic                                rsp_ready_res,
   output logic                                rsp_done_res,
   output logic [1:0]                          rsp_status,
   output logic [7:0]                          rsp_read_data,
   // delay register write
   input  logic                                csr_wr_en,
   input  logic [i2cmbs_pkg::DELAY_W-1:0]      csr_wr_data
);

   localparam int unsigned BW = i2cmbs_pkg::BITS_W;
   localparam int unsigned DW = i2cmbs_pkg::DELAY_W;

   i2cmbs_pkg::seq_state_type state_ff, state_in;
   logic [BW-1:0]  bits_left_ff, bits_left_in;
   logic [7:0]     shift_byte_ff, shift_byte_in;
   logic [DW-1:0]  delay_count_ff, delay_count_in;
   logic           nack_choice_ff, nack_choice_in;
   logic           clock_low_ff, clock_low_in;
   logic           data_low_ff, data_low_in;
   logic [7:0]     received_byte_ff, received_byte_in;
   logic [DW-1:0]  delay_ticks_ff;

   logic           done;
   logic [1:0]     status;
   logic [DW-1:0]  delay_load;
   logic           lines_low;
   logic           req_accept;

   i2cmbs_pkg::rsp_item_type new_item;
   i2cmbs_pkg::rsp_item_type out_data_ff, out_data_in;
   i2cmbs_pkg::rsp_item_type skid_data_ff, skid_data_in;
   logic           out_valid_ff, out_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   logic           rsp_pop;

   assign req_accept = req_valid & ~req_stall;
   assign req_stall  = skid_valid_ff;

   // delay register; zero counts as one tick
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ticks_ff <= i2cmbs_pkg::DELAY_RESET;
      end else if (csr_wr_en) begin
         delay_ticks_ff <= csr_wr_data;
      end
   end

   assign delay_load = (delay_ticks_ff == '0) ? DW'(1) : delay_ticks_ff;
   assign lines_low  = ~req_scl_level | ~req_sda_level;

   // next state for one tick
   always_comb begin
      state_in         = state_ff;
      bits_left_in     = bits_left_ff;
      shift_byte_in    = shift_byte_ff;
      delay_count_in   = delay_count_ff;
      nack_choice_in   = nack_choice_ff;
      clock_low_in     = clock_low_ff;
      data_low_in      = data_low_ff;
      received_byte_in = received_byte_ff;
      done             = 1'b0;
      status           = i2cmbs_pkg::STATUS_OK;

      if (state_ff == i2cmbs_pkg::ST_IDLE) begin
         // new command
         case (req_action)
            i2cmbs_pkg::ACT_START: begin
               state_in       = i2cmbs_pkg::ST_S0;
               delay_count_in = delay_load;
            end
            i2cmbs_pkg::ACT_STOP: begin
               clock_low_in   = 1'b1;
               data_low_in    = 1'b1;
               state_in       = i2cmbs_pkg::ST_P0;
               delay_count_in = delay_load;
            end
            i2cmbs_pkg::ACT_WRITE: begin
               shift_byte_in  = req_write_data;
               bits_left_in   = BW'(i2cmbs_pkg::BITS_PER_BYTE);
               clock_low_in   = 1'b1;
               state_in       = i2cmbs_pkg::ST_W0;
               delay_count_in = delay_load;
            end
            i2cmbs_pkg::ACT_READ: begin
               shift_byte_in  = '0;
               bits_left_in   = BW'(i2cmbs_pkg::BITS_PER_BYTE);
               nack_choice_in = req_send_nack;
               clock_low_in   = 1'b1;
               data_low_in    = 1'b0;
               state_in       = i2cmbs_pkg::ST_R0;
               delay_count_in = delay_load;
            end
            i2cmbs_pkg::ACT_BUSY: begin
               clock_low_in   = 1'b0;
               data_low_in    = 1'b0;
               state_in       = i2cmbs_pkg::ST_B0;
               delay_count_in = delay_load;
            end
            default: begin
               state_in = i2cmbs_pkg::ST_IDLE;
            end
         endcase
      end else if (delay_count_ff <= DW'(1)) begin
         // end of a delay unit: apply the next line changes
         delay_count_in = delay_load;
         case (state_ff)
            i2cmbs_pkg::ST_S0: begin
               data_low_in  = 1'b0;
               clock_low_in = 1'b0;
               state_in     = i2cmbs_pkg::ST_S1;
            end
            i2cmbs_pkg::ST_S1: begin
               if (lines_low) begin
                  done   = 1'b1;
                  status = i2cmbs_pkg::STATUS_BUSY;
               end else begin
                  data_low_in = 1'b1;
                  state_in    = i2cmbs_pkg::ST_S2;
               end
            end
            i2cmbs_pkg::ST_S2: begin
               clock_low_in = 1'b1;
               done         = 1'b1;
            end
            i2cmbs_pkg::ST_P0: begin
               clock_low_in = 1'b0;
               state_in     = i2cmbs_pkg::ST_P1;
            end
            i2cmbs_pkg::ST_P1: begin
               data_low_in = 1'b0;
               state_in    = i2cmbs_pkg::ST_P2;
            end
            i2cmbs_pkg::ST_B0: begin
               done   = 1'b1;
               status = lines_low ? i2cmbs_pkg::STATUS_BUSY : i2cmbs_pkg::STATUS_OK;
            end
            i2cmbs_pkg::ST_W0: begin
               data_low_in  = ~shift_byte_ff[7];
               bits_left_in = bits_left_ff - BW'(1);
               state_in     = i2cmbs_pkg::ST_WA;
            end
            i2cmbs_pkg::ST_WA: begin
               clock_low_in  = 1'b0;
               shift_byte_in = {shift_byte_ff[6:0], 1'b0};
               state_in      = i2cmbs_pkg::ST_WB;
            end
            i2cmbs_pkg::ST_WB: begin
               clock_low_in = 1'b1;
               state_in     = i2cmbs_pkg::ST_WC;
            end
            i2cmbs_pkg::ST_WC: begin
               if (bits_left_ff != '0) begin
                  data_low_in  = ~shift_byte_ff[7];
                  bits_left_in = bits_left_ff - BW'(1);
                  state_in     = i2cmbs_pkg::ST_WA;
               end else begin
                  data_low_in = 1'b0;
                  state_in    = i2cmbs_pkg::ST_WD;
               end
            end
            i2cmbs_pkg::ST_WD: begin
               clock_low_in = 1'b0;
               state_in     = i2cmbs_pkg::ST_WE;
            end
            i2cmbs_pkg::ST_WE: begin
               // acknowledge sample: high means no-ack
               nack_choice_in = req_sda_level;
               clock_low_in   = 1'b1;
               state_in       = i2cmbs_pkg::ST_WF;
            end
            i2cmbs_pkg::ST_WF: begin
               done   = 1'b1;
               status = nack_choice_ff ? i2cmbs_pkg::STATUS_NACK : i2cmbs_pkg::STATUS_OK;
            end
            i2cmbs_pkg::ST_R0: begin
               clock_low_in = 1'b0;
               state_in     = i2cmbs_pkg::ST_RA;
            end
            i2cmbs_pkg::ST_RA: begin
               shift_byte_in = {shift_byte_ff[6:0], req_sda_level};
               bits_left_in  = bits_left_ff - BW'(1);
               clock_low_in  = 1'b1;
               state_in      = i2cmbs_pkg::ST_RB;
            end
            i2cmbs_pkg::ST_RB: begin
               if (bits_left_ff != '0) begin
                  clock_low_in = 1'b0;
                  state_in     = i2cmbs_pkg::ST_RA;
               end else begin
                  data_low_in = ~nack_choice_ff;
                  state_in    = i2cmbs_pkg::ST_RC;
               end
            end
            i2cmbs_pkg::ST_RC: begin
               clock_low_in = 1'b0;
               state_in     = i2cmbs_pkg::ST_RD;
            end
            i2cmbs_pkg::ST_RD: begin
               clock_low_in = 1'b1;
               state_in     = i2cmbs_pkg::ST_RE;
            end
            i2cmbs_pkg::ST_RE: begin
               received_byte_in = shift_byte_ff;
               done             = 1'b1;
            end
            default: begin
               done = 1'b1;
            end
         endcase
         // command complete: back to idle, delay cleared
         if (done) begin
            state_in       = i2cmbs_pkg::ST_IDLE;
            delay_count_in = '0;
         end
      end else begin
         delay_count_in = delay_count_ff - DW'(1);
      end
   end

   // sequencer state, advanced once per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= i2cmbs_pkg::ST_IDLE;
         bits_left_ff     <= '0;
         shift_byte_ff    <= '0;
         delay_count_ff   <= '0;
         nack_choice_ff   <= 1'b0;
         clock_low_ff     <= 1'b0;
         data_low_ff      <= 1'b0;
         received_byte_ff <= '0;
      end else if (req_accept) begin
         state_ff         <= state_in;
         bits_left_ff     <= bits_left_in;
         shift_byte_ff    <= shift_byte_in;
         delay_count_ff   <= delay_count_in;
         nack_choice_ff   <= nack_choice_in;
         clock_low_ff     <= clock_low_in;
         data_low_ff      <= data_low_in;
         received_byte_ff <= received_byte_in;
      end
   end

   // result item for this tick
   always_comb begin
      new_item.scl_pull_low = clock_low_in;
      new_item.sda_pull_low = data_low_in;
      new_item.ready_res    = (state_in == i2cmbs_pkg::ST_IDLE);
      new_item.done_res     = done;
      new_item.status       = status;
      new_item.read_data    = received_byte_in;
   end

   // two-entry output buffer: result register in front, skid register behind
   assign rsp_pop = out_valid_ff & ~rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff) begin
         if (req_accept) begin
            out_valid_in = 1'b1;
            out_data_in  = new_item;
         end
      end else if (!skid_valid_ff) begin
         if (rsp_pop && req_accept) begin
            out_data_in = new_item;
         end else if (req_accept) begin
            skid_valid_in = 1'b1;
            skid_data_in  = new_item;
         end else if (rsp_pop) begin
            out_valid_in = 1'b0;
         end
      end else if (rsp_pop) begin
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_scl_pull_low = out_data_ff.scl_pull_low;
   assign rsp_sda_pull_low = out_data_ff.sda_pull_low;
   assign rsp_ready_res    = out_data_ff.ready_res;
   assign rsp_done_res     = out_data_ff.done_res;
   assign rsp_status       = out_data_ff.status;
   assign rsp_read_data    = out_data_ff.read_data;

   // skid entry only ever sits behind a full result register
   `I2CMBS_ASSERT_NOW(a_skid_behind_out, skid_valid_ff, out_valid_ff)
   // a completing command always reports idle
   `I2CMBS_ASSERT_NOW(a_done_is_idle, rsp_valid && rsp_done_res, rsp_ready_res)
   // no delay is pending while idle
   `I2CMBS_ASSERT_NOW(a_idle_no_delay, state_ff == i2cmbs_pkg::ST_IDLE, delay_count_ff == '0)
   // a valid command taken while idle starts a sequence
   `I2CMBS_ASSERT_NEXT(a_cmd_starts,
      req_accept && state_ff == i2cmbs_pkg::ST_IDLE &&
      (req_action == i2cmbs_pkg::ACT_START || req_action == i2cmbs_pkg::ACT_STOP ||
       req_action == i2cmbs_pkg::ACT_WRITE || req_action == i2cmbs_pkg::ACT_READ ||
       req_action == i2cmbs_pkg::ACT_BUSY),
      state_ff != i2cmbs_pkg::ST_IDLE)

endmodule

// ===== tb/i2c_seq_checker.sv =====
// Watches both channels of the I2C bit sequencer, predicts every result item
// and compares it field by field with what the block returns.
module i2c_seq_checker
   import i2cmbs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [2:0]           req_action,
   input  logic [7:0]           req_write_data,
   input  logic                 req_send_nack,
   input  logic                 req_scl_level,
   input  logic                 req_sda_level,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 rsp_scl_pull_low,
   input  logic                 rsp_sda_pull_low,
   input  logic                 rsp_ready_res,
   input  logic                 rsp_done_res,
   input  logic [1:0]           rsp_status,
   input  logic [7:0]           rsp_read_data,
   input  logic                 csr_wr_en,
   input  logic [DELAY_W-1:0]   csr_wr_data,
   output int                   mismatch_count,
   output int                   ticks_pending
);

   // predicted sequencer state
   seq_state_type       step;
   logic [BITS_W-1:0]   bits_left;
   logic [7:0]          shreg;
   logic [DELAY_W-1:0]  delay_left;
   logic [DELAY_W-1:0]  unit_ticks;
   logic                nack_sel;
   logic                scl_low;
   logic                sda_low;
   logic [1:0]          last_status;
   logic [7:0]          rx_byte;
   logic                tick_done;

   rsp_item_type        expected_ticks[$];

   // enter a step and reload the delay unit; zero counts as one tick
   function automatic void load_delay(input seq_state_type nxt);
      step       = nxt;
      delay_left = (unit_ticks == '0) ? DELAY_W'(1) : unit_ticks;
   endfunction

   function automatic void end_command(input logic [1:0] st);
      step        = ST_IDLE;
      delay_left  = '0;
      last_status = st;
      tick_done   = 1'b1;
   endfunction

   // put the next data bit on SDA while SCL is held low
   function automatic void drive_write_bit();
      sda_low   = ~shreg[7];
      bits_left = bits_left - BITS_W'(1);
      load_delay(ST_WA);
   endfunction

   // line changes at the end of a delay unit
   function automatic void delay_expired(input logic scl, input logic sda);
      case (step)
         ST_S0: begin
            sda_low = 1'b0;
            scl_low = 1'b0;
            load_delay(ST_S1);
         end
         ST_S1: begin
            if (!scl || !sda) begin
               end_command(STATUS_BUSY);
            end else begin
               sda_low = 1'b1;
               load_delay(ST_S2);
            end
         end
         ST_S2: begin
            scl_low = 1'b1;
            end_command(STATUS_OK);
         end
         ST_P0: begin
            scl_low = 1'b0;
            load_delay(ST_P1);
         end
         ST_P1: begin
            sda_low = 1'b0;
            load_delay(ST_P2);
         end
         ST_P2: end_command(STATUS_OK);
         ST_B0: end_command((!scl || !sda) ? STATUS_BUSY : STATUS_OK);
         ST_W0: drive_write_bit();
         ST_WA: begin
            scl_low = 1'b0;
            shreg   = shreg << 1;
            load_delay(ST_WB);
         end
         ST_WB: begin
            scl_low = 1'b1;
            load_delay(ST_WC);
         end
         ST_WC: begin
            if (bits_left != '0) begin
               drive_write_bit();
            end else begin
               sda_low = 1'b0;
               load_delay(ST_WD);
            end
         end
         ST_WD: begin
            scl_low = 1'b0;
            load_delay(ST_WE);
         end
         ST_WE: begin
            // acknowledge sample: high means the target did not answer
            nack_sel = sda;
            scl_low  = 1'b1;
            load_delay(ST_WF);
         end
         ST_WF: end_command(nack_sel ? STATUS_NACK : STATUS_OK);
         ST_R0: begin
            scl_low = 1'b0;
            load_delay(ST_RA);
         end
         ST_RA: begin
            shreg     = {shreg[6:0], sda};
            bits_left = bits_left - BITS_W'(1);
            scl_low   = 1'b1;
            load_delay(ST_RB);
         end
         ST_RB: begin
            if (bits_left != '0) begin
               scl_low = 1'b0;
               load_delay(ST_RA);
            end else begin
               sda_low = ~nack_sel;
               load_delay(ST_RC);
            end
         end
         ST_RC: begin
            scl_low = 1'b0;
            load_delay(ST_RD);
         end
         ST_RD: begin
            scl_low = 1'b1;
            load_delay(ST_RE);
         end
         ST_RE: begin
            rx_byte = shreg;
            end_command(STATUS_OK);
         end
         default: end_command(STATUS_OK);
      endcase
   endfunction

   // one tick of the sequencer: returns the result item it produces
   function automatic rsp_item_type advance_bus_tick(input logic [2:0] act,
                                                     input logic [7:0] wdata,
                                                     input logic nack,
                                                     input logic scl,
                                                     input logic sda);
      rsp_item_type res;
      tick_done = 1'b0;
      if (step == ST_IDLE) begin
         case (act)
            ACT_START: load_delay(ST_S0);
            ACT_STOP: begin
               scl_low = 1'b1;
               sda_low = 1'b1;
               load_delay(ST_P0);
            end
            ACT_WRITE: begin
               shreg     = wdata;
               bits_left = BITS_W'(BITS_PER_BYTE);
               scl_low   = 1'b1;
               load_delay(ST_W0);
            end
            ACT_READ: begin
               shreg     = '0;
               bits_left = BITS_W'(BITS_PER_BYTE);
               nack_sel  = nack;
               scl_low   = 1'b1;
               sda_low   = 1'b0;
               load_delay(ST_R0);
            end
            ACT_BUSY: begin
               sda_low = 1'b0;
               scl_low = 1'b0;
               load_delay(ST_B0);
            end
            default: ;
         endcase
      end else if (delay_left <= DELAY_W'(1)) begin
         delay_left = '0;
         delay_expired(scl, sda);
      end else begin
         delay_left = delay_left - DELAY_W'(1);
      end
      res.scl_pull_low = scl_low;
      res.sda_pull_low = sda_low;
      res.ready_res    = (step == ST_IDLE);
      res.done_res     = tick_done;
      res.status       = tick_done ? last_status : STATUS_OK;
      res.read_data    = rx_byte;
      return res;
   endfunction

   function automatic int compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   rsp_item_type want;
   rsp_item_type got;
   int           errs;

   always @(posedge clock) begin
      errs = 0;
      if (reset) begin
         step        = ST_IDLE;
         bits_left   = '0;
         shreg       = '0;
         delay_left  = '0;
         unit_ticks  = DELAY_RESET;
         nack_sel    = 1'b0;
         scl_low     = 1'b0;
         sda_low     = 1'b0;
         last_status = STATUS_OK;
         rx_byte     = '0;
         expected_ticks.delete();
      end else begin
         // result side first: a result never leaves on the edge its item enters
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_scl_pull_low, rsp_sda_pull_low, rsp_ready_res, rsp_done_res,
                   rsp_status, rsp_read_data};
            if (expected_ticks.size() == 0) begin
               $display("%0t: result item with none expected, got %0h", $time, got);
               errs++;
            end else begin
               want = expected_ticks.pop_front();
               errs += compare_field("scl_pull_low", 8'(want.scl_pull_low),
                                     8'(got.scl_pull_low));
               errs += compare_field("sda_pull_low", 8'(want.sda_pull_low),
                                     8'(got.sda_pull_low));
               errs += compare_field("ready_res", 8'(want.ready_res), 8'(got.ready_res));
               errs += compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
               errs += compare_field("status", 8'(want.status), 8'(got.status));
               errs += compare_field("read_data", want.read_data, got.read_data);
            end
         end
         if (req_valid && !req_stall)
            expected_ticks.push_back(advance_bus_tick(req_action, req_write_data,
                                                      req_send_nack, req_scl_level,
                                                      req_sda_level));
         // new delay length applies from the next delay load
         if (csr_wr_en)
            unit_ticks = csr_wr_data;
      end
      mismatch_count <= mismatch_count + errs;
      ticks_pending  <= expected_ticks.size();
   end

endmodule

// ===== tb/tb.sv =====
module tb;
   import i2cmbs_pkg::*;

   localparam logic [2:0] ACT_RSVD_6  = 3'd6;
   localparam logic [2:0] ACT_RSVD_7  = 3'd7;
   localparam int         CYCLE_LIMIT = 1_500_000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [2:0]          req_action = ACT_NONE;
   logic [7:0]          req_write_data = '0;
   logic                req_send_nack = 1'b0;
   logic                req_scl_level = 1'b1;
   logic                req_sda_level = 1'b1;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_scl_pull_low;
   logic                rsp_sda_pull_low;
   logic                rsp_ready_res;
   logic                rsp_done_res;
   logic [1:0]          rsp_status;
   logic [7:0]          rsp_read_data;
   logic                csr_wr_en = 1'b0;
   logic [DELAY_W-1:0]  csr_wr_data = '0;

   int                  mismatch_count;
   int                  ticks_pending;
   int                  cycle_count = 0;
   int                  done_count = 0;
   logic                last_ready = 1'b1;
   logic                req_idle_on = 1'b0;
   logic                stall_on = 1'b0;
   int                  stall_left = 0;
   int                  stall_roll;

   i2c_master_bit_sequencer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_write_data   (req_write_data),
      .req_send_nack    (req_send_nack),
      .req_scl_level    (req_scl_level),
      .req_sda_level    (req_sda_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_scl_pull_low (rsp_scl_pull_low),
      .rsp_sda_pull_low (rsp_sda_pull_low),
      .rsp_ready_res    (rsp_ready_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_status       (rsp_status),
      .rsp_read_data    (rsp_read_data),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   i2c_seq_checker seq_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_write_data   (req_write_data),
      .req_send_nack    (req_send_nack),
      .req_scl_level    (req_scl_level),
      .req_sda_level    (req_sda_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_scl_pull_low (rsp_scl_pull_low),
      .rsp_sda_pull_low (rsp_sda_pull_low),
      .rsp_ready_res    (rsp_ready_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_status       (rsp_status),
      .rsp_read_data    (rsp_read_data),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .mismatch_count   (mismatch_count),
      .ticks_pending    (ticks_pending)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // track completions and the idle flag of the latest result item
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         last_ready <= rsp_ready_res;
         if (rsp_done_res)
            done_count <= done_count + 1;
      end
   end

   // result side back-pressure: mostly short stalls, a few long ones
   always @(posedge clock) begin
      if (reset || !stall_on) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 12) begin
            rsp_stall  <= 1'b1;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // drive one tick item and wait until it is taken; valid stays high on return
   task automatic send_tick(input logic [2:0] act, input logic [7:0] data,
                            input logic nack, input logic scl, input logic sda);
      int gap;
      int roll;
      gap = 0;
      if (req_idle_on) begin
         roll = $urandom_range(0, 99);
         if (roll >= 92)
            gap = $urandom_range(5, 30);
         else if (roll >= 70)
            gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_write_data <= data;
      req_send_nack  <= nack;
      req_scl_level  <= scl;
      req_sda_level  <= sda;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // issue a command, then idle ticks at fixed line levels until it completes
   task automatic run_cmd(input logic [2:0] act, input logic [7:0] data,
                          input logic nack, input logic scl, input logic sda,
                          input logic barge_in);
      int seen;
      seen = done_count;
      send_tick(act, data, nack, scl, sda);
      // a read command while busy must be dropped
      if (barge_in)
         send_tick(ACT_READ, 8'h3C, 1'b0, scl, sda);
      while (done_count == seen)
         send_tick(ACT_NONE, 8'h00, 1'b0, scl, sda);
   endtask

   // wait for all results and an idle sequencer
   task automatic settle();
      logic quiet;
      quiet = 1'b0;
      req_valid <= 1'b0;
      while (!quiet) begin
         @(posedge clock);
         if (ticks_pending == 0) begin
            if (last_ready) begin
               quiet = 1'b1;
            end else begin
               send_tick(ACT_NONE, 8'h00, 1'b0, 1'b1, 1'b1);
               req_valid <= 1'b0;
            end
         end
      end
   endtask

   task automatic set_delay(input logic [DELAY_W-1:0] ticks);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ticks;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // random commands mixed with idle ticks; lines mostly high
   task automatic random_ticks(input int count);
      int         roll;
      logic [2:0] act;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 45)
            act = ACT_NONE;
         else if (roll < 55)
            act = ACT_START;
         else if (roll < 63)
            act = ACT_STOP;
         else if (roll < 78)
            act = ACT_WRITE;
         else if (roll < 91)
            act = ACT_READ;
         else if (roll < 97)
            act = ACT_BUSY;
         else
            act = ($urandom_range(0, 1) == 0) ? ACT_RSVD_6 : ACT_RSVD_7;
         send_tick(act, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   ($urandom_range(0, 9) != 0), ($urandom_range(0, 4) > 1));
      end
   endtask

   int phase_delay[6] = '{1, 2, 0, 3, 1, 4};

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset delay, then one-tick units
      stall_on <= 1'b1;
      run_cmd(ACT_BUSY, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
      set_delay(16'd1);
      run_cmd(ACT_START, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
      run_cmd(ACT_START, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
      run_cmd(ACT_START, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
      run_cmd(ACT_BUSY, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
      run_cmd(ACT_BUSY, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
      run_cmd(ACT_WRITE, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
      run_cmd(ACT_WRITE, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0);
      run_cmd(ACT_WRITE, 8'hA5, 1'b0, 1'b1, 1'b0, 1'b1);
      run_cmd(ACT_READ, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
      run_cmd(ACT_READ, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0);
      run_cmd(ACT_STOP, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
      send_tick(ACT_RSVD_6, 8'hFF, 1'b1, 1'b1, 1'b1);
      send_tick(ACT_RSVD_7, 8'h00, 1'b0, 1'b0, 1'b0);
      send_tick(ACT_NONE, 8'h55, 1'b1, 1'b1, 1'b1);
      // zero delay behaves as one tick
      set_delay(16'd0);
      run_cmd(ACT_READ, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
      run_cmd(ACT_WRITE, 8'h5A, 1'b0, 1'b1, 1'b0, 1'b0);

      // long delay unit, one busy check, no idling
      set_delay(16'h0100);
      stall_on <= 1'b0;
      run_cmd(ACT_BUSY, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);

      // random phases over several delay lengths
      for (int p = 0; p < 6; p++) begin
         set_delay(DELAY_W'(phase_delay[p]));
         req_idle_on <= (p != 2);
         stall_on    <= (p != 4);
         random_ticks(130);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (ticks_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && ticks_pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/i2cmbs_pkg.sv
sv/i2c_master_bit_sequencer.sv
tb/i2c_seq_checker.sv
tb/tb.sv
